### sv/qpd_pkg.sv
`timescale 1ns / 1ps

package qpd_pkg;

    localparam int MAX_LEVELS_DEF = 32;
    localparam int CFG_W          = 6;
    localparam int COORD_W        = 32;
    localparam int NIBBLE_BITS    = 4;
    localparam int LEAF_SIDE      = 2;
    localparam int LEAF_HALF      = LEAF_SIDE / 2;

    localparam logic [CFG_W-1:0] TREE_LEVELS_RST = CFG_W'(16);

    typedef enum logic [2:0] {
        PH_ROOT  = 3'd0,
        PH_OPEN  = 3'd1,
        PH_TAIL  = 3'd2,
        PH_CHILD = 3'd3,
        PH_CLOSE = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERR   = 3'd6
    } t_phase;

    // everything one tree bit produces, handed from the parser to the output stage
    typedef struct packed {
        logic [NIBBLE_BITS-1:0] mask;
        logic [COORD_W-1:0]     row;
        logic [COORD_W-1:0]     col;
        logic                   used;
        logic                   fin;
        logic                   mal;
    } t_bundle;

endpackage

### sv/qpd_step.sv
`timescale 1ns / 1ps

module qpd_step import qpd_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_go,
    input  logic                   i_tree_bit,
    input  logic [NIBBLE_BITS-1:0] i_leaf_nibble,
    output t_bundle                o_bundle
);

    localparam int DW = $clog2(MAX_LEVELS + 1);
    localparam int IW = $clog2(MAX_LEVELS);
    localparam logic [6:0] MAX7 = 7'(MAX_LEVELS);

    logic [CFG_W-1:0]   r_levels;
    logic [1:0]         r_stack [MAX_LEVELS];
    logic [DW-1:0]      r_depth, n_depth;
    t_phase             r_phase, n_phase;
    logic [1:0]         r_skip, n_skip;
    logic [COORD_W-1:0] r_row, n_row, r_col, n_col;

    logic [6:0]         lv7, d7, pos, hpos;
    logic [DW-1:0]      dm1;
    logic [IW-1:0]      rd_idx;
    logic [1:0]         k, kn;
    logic [COORD_W-1:0] keep, half;

    t_phase             c_phase;
    logic [DW-1:0]      c_depth;
    logic [COORD_W-1:0] c_row, c_col;
    logic               c_fin;

    logic               wr_en;
    logic [1:0]         wr_val;
    logic               fin, mal, used;

    // side exponent saturated into 1..MAX_LEVELS
    always_comb begin
        if (r_levels == '0) begin
            lv7 = 7'd1;
        end else if ({1'b0, r_levels} > MAX7) begin
            lv7 = MAX7;
        end else begin
            lv7 = {1'b0, r_levels};
        end
    end

    assign d7     = 7'(r_depth);
    assign dm1    = r_depth - DW'(1);
    // child scan reads its own level, a close reads the parent
    assign rd_idx = (r_phase == PH_CHILD) ? r_depth[IW-1:0] : dm1[IW-1:0];
    assign k      = r_stack[rd_idx];
    assign kn     = k + 2'd1;
    assign pos    = lv7 - d7;
    assign hpos   = lv7 - d7 - 7'd1;
    assign keep   = ~(COORD_W'(1) << pos);
    assign half   = COORD_W'(1) << hpos;

    // outcome of closing the current node
    always_comb begin
        c_phase = PH_ERR;
        c_depth = r_depth;
        c_row   = r_row;
        c_col   = r_col;
        c_fin   = 1'b0;
        if (r_depth == '0) begin
            c_phase = PH_DONE;
            c_fin   = 1'b1;
        end else if (d7 > MAX7 || d7 >= lv7) begin
            c_phase = PH_ERR;
        end else begin
            c_row   = r_row & keep;
            c_col   = r_col & keep;
            c_depth = dm1;
            c_phase = (k == 2'd3) ? PH_CLOSE : PH_CHILD;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_depth = r_depth;
        n_skip  = r_skip;
        n_row   = r_row;
        n_col   = r_col;
        wr_en   = 1'b0;
        wr_val  = 2'd0;
        fin     = 1'b0;
        mal     = 1'b0;
        used    = 1'b0;
        unique case (r_phase)
            PH_ROOT: begin
                if (i_tree_bit) begin
                    n_depth = '0;
                    n_phase = PH_OPEN;
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_OPEN: begin
                if (!i_tree_bit) begin
                    n_phase = c_phase;
                    n_depth = c_depth;
                    n_row   = c_row;
                    n_col   = c_col;
                    fin     = c_fin;
                end else if (d7 + 7'd1 >= lv7) begin
                    used    = 1'b1;
                    n_skip  = 2'd2;
                    n_phase = PH_TAIL;
                end else if (d7 < MAX7) begin
                    wr_en   = 1'b1;
                    wr_val  = 2'd0;
                    n_depth = r_depth + DW'(1);
                    n_phase = PH_OPEN;
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_TAIL: begin
                if (i_tree_bit) begin
                    n_phase = PH_ERR;
                end else begin
                    n_skip = r_skip - 2'd1;
                    if (n_skip == 2'd0) begin
                        n_phase = c_phase;
                        n_depth = c_depth;
                        n_row   = c_row;
                        n_col   = c_col;
                        fin     = c_fin;
                    end
                end
            end
            PH_CHILD: begin
                if (!i_tree_bit || d7 >= MAX7 || d7 + 7'd1 >= lv7 || k == 2'd3) begin
                    n_phase = PH_ERR;
                end else begin
                    wr_en   = 1'b1;
                    wr_val  = kn;
                    if (kn[1]) begin
                        n_row = r_row | half;
                    end
                    if (kn[0]) begin
                        n_col = r_col | half;
                    end
                    n_depth = r_depth + DW'(1);
                    n_phase = PH_OPEN;
                end
            end
            PH_CLOSE: begin
                if (i_tree_bit) begin
                    n_phase = PH_ERR;
                end else begin
                    n_phase = c_phase;
                    n_depth = c_depth;
                    n_row   = c_row;
                    n_col   = c_col;
                    fin     = c_fin;
                end
            end
            PH_DONE: begin
                fin = 1'b1;
                mal = 1'b1;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase
        if (n_phase == PH_ERR) begin
            mal = 1'b1;
        end
    end

    always_comb begin
        o_bundle.mask = used ? i_leaf_nibble : '0;
        o_bundle.row  = r_row;
        o_bundle.col  = r_col;
        o_bundle.used = used;
        o_bundle.fin  = fin;
        o_bundle.mal  = mal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_levels <= i_rst_n ? i_cfg_data : TREE_LEVELS_RST;
            r_phase  <= PH_ROOT;
            r_depth  <= '0;
            r_skip   <= 2'd0;
            r_row    <= '0;
            r_col    <= '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_stack[i] <= 2'd0;
            end
        end else if (i_go) begin
            r_phase <= n_phase;
            r_depth <= n_depth;
            r_skip  <= n_skip;
            r_row   <= n_row;
            r_col   <= n_col;
            if (wr_en) begin
                r_stack[r_depth[IW-1:0]] <= wr_val;
            end
        end
    end

endmodule

### sv/qpd_emit.sv
`timescale 1ns / 1ps

module qpd_emit import qpd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_bundle            i_bundle,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_row,
    output logic [COORD_W-1:0] o_col,
    output logic               o_pair_valid,
    output logic               o_last,
    output logic               o_leaf_used,
    output logic               o_finished,
    output logic               o_malformed
);

    logic                   r_valid;
    t_bundle                r_b;
    logic [NIBBLE_BITS-1:0] low;
    logic                   last, take;

    // lowest set bit of the leaf mask goes out first
    assign low  = r_b.mask & (~r_b.mask + NIBBLE_BITS'(1));
    assign last = (r_b.mask & (r_b.mask - NIBBLE_BITS'(1))) == '0;
    assign take = r_valid && i_ready;

    assign o_free       = !r_valid || (take && last);
    assign o_valid      = r_valid;
    assign o_pair_valid = r_b.mask != '0;
    assign o_last       = last;
    assign o_leaf_used  = r_b.used;
    assign o_finished   = r_b.fin;
    assign o_malformed  = r_b.mal;

    always_comb begin
        o_row = '0;
        o_col = '0;
        if (r_b.mask != '0) begin
            o_row = r_b.row + ((low[2] || low[3]) ? COORD_W'(LEAF_HALF) : '0);
            o_col = r_b.col + ((low[1] || low[3]) ? COORD_W'(LEAF_HALF) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (take && last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b <= i_bundle;
        end else if (take) begin
            r_b.mask <= r_b.mask & ~low;
        end
    end

endmodule

### sv/quadtree_parens_decoder.sv
`timescale 1ns / 1ps

// Quadtree decoder for a balanced-parentheses tree stream, one tree bit per input
// word. An accepted word sits in an input register, is parsed against the level stack
// and coordinate bases once the output stage is free, and its results are loaded into
// the output register. A word produces max(1, n) output words, n being the set bits
// of a consumed leaf nibble; the output stage sends one word per cycle unless i_ready
// stalls it, so a word with no entries or one entry goes through at one per cycle and
// a leaf with n entries holds the input side until its last entry is taken. Writing
// the config register restarts the decode; the user must write it only while the block is idle (not enforced).
module quadtree_parens_decoder import qpd_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_tree_bit,
    input  logic [NIBBLE_BITS-1:0] i_leaf_nibble,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_W-1:0]     o_row,
    output logic [COORD_W-1:0]     o_col,
    output logic                   o_pair_valid,
    output logic                   o_last,
    output logic                   o_leaf_used,
    output logic                   o_finished,
    output logic                   o_malformed
);

    logic                   r_in_valid;
    logic                   r_in_bit;
    logic [NIBBLE_BITS-1:0] r_in_nib;
    logic                   free, go;
    t_bundle                bundle;

    assign go      = r_in_valid && free;
    assign o_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_bit <= i_tree_bit;
            r_in_nib <= i_leaf_nibble;
        end
    end

    qpd_step #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_go         (go),
        .i_tree_bit   (r_in_bit),
        .i_leaf_nibble(r_in_nib),
        .o_bundle     (bundle)
    );

    qpd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go),
        .i_bundle    (bundle),
        .o_free      (free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_pair_valid(o_pair_valid),
        .o_last      (o_last),
        .o_leaf_used (o_leaf_used),
        .o_finished  (o_finished),
        .o_malformed (o_malformed)
    );

endmodule

### sv/qpd_checker.sv
`timescale 1ns / 1ps

module qpd_checker import qpd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [COORD_W-1:0] o_row,
    input logic [COORD_W-1:0] o_col,
    input logic               o_pair_valid,
    input logic               o_last,
    input logic               o_leaf_used,
    input logic               o_finished,
    input logic               o_malformed
);

    // a word with no entry is the only word of its tree bit
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pair_valid) |-> o_last)
        else $error("empty result not marked last");

    // entries only come out of a consumed leaf
    a_entry_from_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pair_valid) |-> o_leaf_used)
        else $error("entry without consumed leaf");

    a_finish_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> !o_pair_valid)
        else $error("entry reported with finish");

    // the rest of a leaf follows straight on
    a_leaf_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (o_valid && o_leaf_used && o_pair_valid))
        else $error("leaf burst broken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_row) && $stable(o_col)))
        else $error("stalled output word changed");

endmodule

bind quadtree_parens_decoder qpd_checker u_chk (.*);

### test/qpd_pair_checker.sv
`timescale 1ns / 1ps

module qpd_pair_checker import qpd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic                   i_tree_bit,
    input  logic [NIBBLE_BITS-1:0] i_leaf_nibble,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [COORD_W-1:0]     i_row,
    input  logic [COORD_W-1:0]     i_col,
    input  logic                   i_pair_valid,
    input  logic                   i_last,
    input  logic                   i_leaf_used,
    input  logic                   i_finished,
    input  logic                   i_malformed,
    output int                     o_fail_count,
    output int                     o_outstanding
);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               pair_valid;
        logic               last;
        logic               leaf_used;
        logic               finished;
        logic               malformed;
    } t_pair_word;

    t_pair_word         due_words[$];
    t_pair_word         head_word;
    int                 fails = 0;

    // shadow of the decoder state
    logic [1:0]         child_idx [MAX_LEVELS_DEF];
    logic [5:0]         node_depth;
    t_phase             phase;
    logic [1:0]         skip_left;
    logic [COORD_W-1:0] corner_row;
    logic [COORD_W-1:0] corner_col;
    logic [CFG_W-1:0]   levels_reg;

    assign o_fail_count = fails;

    function automatic void restart_decode();
        foreach (child_idx[j]) child_idx[j] = '0;
        node_depth = '0;
        phase      = PH_ROOT;
        skip_left  = '0;
        corner_row = '0;
        corner_col = '0;
    endfunction

    function automatic int side_levels();
        if (levels_reg < 1) return 1;
        if (levels_reg > MAX_LEVELS_DEF) return MAX_LEVELS_DEF;
        return int'(levels_reg);
    endfunction

    // step back to the parent; returns 1 when the root itself was closed
    function automatic bit close_node(int lv);
        int                 p;
        logic [COORD_W-1:0] keep_mask;
        if (node_depth == 0) begin
            phase = PH_DONE;
            return 1'b1;
        end
        p = int'(node_depth) - 1;
        if (p >= MAX_LEVELS_DEF || p + 1 >= lv) begin
            phase = PH_ERR;
            return 1'b0;
        end
        keep_mask  = ~(COORD_W'(1) << (lv - 1 - p));
        corner_row = corner_row & keep_mask;
        corner_col = corner_col & keep_mask;
        node_depth = 6'(p);
        phase      = (child_idx[p] == 2'd3) ? PH_CLOSE : PH_CHILD;
        return 1'b0;
    endfunction

    function automatic void decode_bit(logic tree_bit, logic [NIBBLE_BITS-1:0] nib);
        int                 lv;
        int                 d;
        int                 k;
        int                 i;
        int                 first;
        int                 n;
        logic               fin;
        logic               mal;
        logic               used;
        logic [COORD_W-1:0] half;
        t_pair_word         entry;
        lv    = side_levels();
        d     = int'(node_depth);
        first = due_words.size();
        n     = 0;
        fin   = 1'b0;
        mal   = 1'b0;
        used  = 1'b0;
        case (phase)
            PH_ROOT: begin
                if (tree_bit) begin
                    node_depth = '0;
                    phase      = PH_OPEN;
                end else begin
                    mal   = 1'b1;
                    phase = PH_ERR;
                end
            end
            PH_OPEN: begin
                if (!tree_bit) begin
                    fin = close_node(lv);
                end else if (d + 1 >= lv) begin
                    // 2x2 level: the leaf nibble goes out as one word per set bit
                    used = 1'b1;
                    for (i = 0; i < NIBBLE_BITS; i++) begin
                        if (nib[i]) begin
                            entry            = '0;
                            entry.row        = corner_row + COORD_W'((i / 2) * LEAF_HALF);
                            entry.col        = corner_col + COORD_W'((i % 2) * LEAF_HALF);
                            entry.pair_valid = 1'b1;
                            due_words.push_back(entry);
                            n++;
                        end
                    end
                    skip_left = 2'd2;
                    phase     = PH_TAIL;
                end else if (d < MAX_LEVELS_DEF) begin
                    child_idx[d] = '0;
                    node_depth   = 6'(d + 1);
                    phase        = PH_OPEN;
                end else begin
                    mal   = 1'b1;
                    phase = PH_ERR;
                end
            end
            PH_TAIL: begin
                if (tree_bit) begin
                    mal   = 1'b1;
                    phase = PH_ERR;
                end else begin
                    skip_left = skip_left - 2'd1;
                    if (skip_left == 0) fin = close_node(lv);
                end
            end
            PH_CHILD: begin
                if (!tree_bit || d >= MAX_LEVELS_DEF || d + 1 >= lv || child_idx[d] == 2'd3) begin
                    mal   = 1'b1;
                    phase = PH_ERR;
                end else begin
                    half         = COORD_W'(1) << (lv - 1 - d);
                    k            = int'(child_idx[d]) + 1;
                    child_idx[d] = 2'(k);
                    if ((k & 2) != 0) corner_row = corner_row | half;
                    if ((k & 1) != 0) corner_col = corner_col | half;
                    node_depth = 6'(d + 1);
                    phase      = PH_OPEN;
                end
            end
            PH_CLOSE: begin
                if (tree_bit) begin
                    mal   = 1'b1;
                    phase = PH_ERR;
                end else begin
                    fin = close_node(lv);
                end
            end
            PH_DONE: begin
                fin = 1'b1;
                mal = 1'b1;
            end
            default: begin
                mal   = 1'b1;
                phase = PH_ERR;
            end
        endcase
        if (phase == PH_ERR) mal = 1'b1;
        if (n == 0) begin
            entry = '0;
            due_words.push_back(entry);
        end
        for (i = first; i < due_words.size(); i++) begin
            due_words[i].last      = (i == due_words.size() - 1);
            due_words[i].leaf_used = used;
            due_words[i].finished  = fin;
            due_words[i].malformed = mal;
        end
    endfunction

    function automatic void check_field(string name, logic [COORD_W-1:0] want,
                                        logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            levels_reg = TREE_LEVELS_RST;
            restart_decode();
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                levels_reg = i_cfg_data;
                restart_decode();
            end
            if (i_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    $error("unexpected word: row %0h col %0h", i_row, i_col);
                    fails++;
                end else begin
                    head_word = due_words.pop_front();
                    check_field("row", head_word.row, i_row);
                    check_field("col", head_word.col, i_col);
                    check_field("pair_valid", COORD_W'(head_word.pair_valid),
                                COORD_W'(i_pair_valid));
                    check_field("last", COORD_W'(head_word.last), COORD_W'(i_last));
                    check_field("leaf_used", COORD_W'(head_word.leaf_used),
                                COORD_W'(i_leaf_used));
                    check_field("finished", COORD_W'(head_word.finished),
                                COORD_W'(i_finished));
                    check_field("malformed", COORD_W'(head_word.malformed),
                                COORD_W'(i_malformed));
                end
            end
            if (i_in_valid && i_in_ready) decode_bit(i_tree_bit, i_leaf_nibble);
        end
        o_outstanding <= due_words.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import qpd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASE_WORDS   = 32;
    localparam int BUSHY_BUDGET  = 24;
    localparam int GROW_BUSHY    = 0;
    localparam int GROW_PATH     = 1;
    localparam int GROW_FAR      = 2;
    localparam int GROW_DEEP     = 3;

    typedef struct packed {
        logic                   open_bit;
        logic [NIBBLE_BITS-1:0] nibble;
    } t_tree_word;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   i_valid       = 1'b0;
    logic                   o_ready;
    logic                   i_tree_bit    = 1'b0;
    logic [NIBBLE_BITS-1:0] i_leaf_nibble = '0;
    logic                   o_valid;
    logic                   i_ready       = 1'b0;
    logic [COORD_W-1:0]     o_row;
    logic [COORD_W-1:0]     o_col;
    logic                   o_pair_valid;
    logic                   o_last;
    logic                   o_leaf_used;
    logic                   o_finished;
    logic                   o_malformed;

    int                     fail_count;
    int                     outstanding;
    int                     cycle_count   = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     hold_reqs     = 0;
    int                     hold_seen     = 0;
    int                     hold_left     = 0;
    int                     words_sent    = 0;
    bit                     stall_next    = 1'b0;
    bit                     muted         = 1'b0;
    bit                     cut_leaf      = 1'b0;
    t_tree_word             tree_words[$];

    quadtree_parens_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_tree_bit    (i_tree_bit),
        .i_leaf_nibble (i_leaf_nibble),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_pair_valid  (o_pair_valid),
        .o_last        (o_last),
        .o_leaf_used   (o_leaf_used),
        .o_finished    (o_finished),
        .o_malformed   (o_malformed)
    );

    qpd_pair_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_tree_bit    (i_tree_bit),
        .i_leaf_nibble (i_leaf_nibble),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_row         (o_row),
        .i_col         (o_col),
        .i_pair_valid  (o_pair_valid),
        .i_last        (o_last),
        .i_leaf_used   (o_leaf_used),
        .i_finished    (o_finished),
        .i_malformed   (o_malformed),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_reqs;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(logic tree_bit, logic [NIBBLE_BITS-1:0] nib);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_tree_bit    <= tree_bit;
        i_leaf_nibble <= nib;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // sends the low n bits of pattern, oldest first
    task automatic send_bits(logic [31:0] pattern, int n, logic [NIBBLE_BITS-1:0] nib);
        int j;
        for (j = n - 1; j >= 0; j--) send_word(pattern[j], nib);
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // restarts the decode, so only once the pipe has drained
    task automatic set_levels(int cfg);
        wait_quiet();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CFG_W'(cfg);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic void put_word(logic open_bit, bit at_leaf);
        t_tree_word w;
        w.open_bit = open_bit;
        if (at_leaf && $urandom_range(3) == 0) w.nibble = '1;
        else w.nibble = NIBBLE_BITS'($urandom_range(15));
        if (!muted) tree_words.push_back(w);
    endfunction

    function automatic void grow_node(int lvl, int eff, int style, bit keep);
        int pick;
        int c;
        put_word(1'b1, 1'b0);
        if (!keep) begin
            put_word(1'b0, 1'b0);
        end else if (lvl + 1 >= eff) begin
            put_word(1'b1, 1'b1);
            put_word(1'b0, 1'b0);
            put_word(1'b0, 1'b0);
            if (cut_leaf) muted = 1'b1;
        end else begin
            // a deep path mostly takes the first quadrant to keep the stream short
            if (style == GROW_FAR) pick = 3;
            else if (style == GROW_DEEP && $urandom_range(4) != 0) pick = 0;
            else pick = int'($urandom_range(3));
            for (c = 0; c < 4; c++) begin
                if (style == GROW_BUSHY)
                    grow_node(lvl + 1, eff, style,
                              tree_words.size() < BUSHY_BUDGET && $urandom_range(99) < 55);
                else
                    grow_node(lvl + 1, eff, style, c == pick);
            end
            put_word(1'b0, 1'b0);
        end
    endfunction

    task automatic run_tree(int cfg, int eff, int style, bit root_open, bit stop_at_leaf,
                            bit may_spoil);
        int j;
        set_levels(cfg);
        if (stall_next) begin
            hold_reqs  <= hold_reqs + 1;
            stall_next = 1'b0;
        end
        tree_words.delete();
        muted    = 1'b0;
        cut_leaf = stop_at_leaf;
        grow_node(0, eff, style, root_open);
        if (may_spoil) begin
            case ($urandom_range(7))
                0: begin
                    j = $urandom_range(tree_words.size() - 1);
                    tree_words[j].open_bit = ~tree_words[j].open_bit;
                end
                1: if (tree_words.size() > 1)
                       repeat ($urandom_range(1, tree_words.size() - 1)) tree_words.pop_back();
                2: begin
                    // trailing words after the root has closed
                    muted = 1'b0;
                    repeat ($urandom_range(1, 3)) put_word(1'($urandom_range(1)), 1'b1);
                end
                default: ;
            endcase
        end
        for (j = 0; j < tree_words.size(); j++)
            send_word(tree_words[j].open_bit, tree_words[j].nibble);
    endtask

    task automatic random_tree();
        int eff;
        int cfg;
        int style;
        int r;
        r = $urandom_range(9);
        if (r < 2) eff = 1;
        else if (r < 5) eff = 2;
        else if (r < 8) eff = 3;
        else if (r < 9) eff = 4;
        else eff = $urandom_range(5, MAX_LEVELS_DEF);
        cfg = eff;
        if (eff == 1 && $urandom_range(2) == 0) cfg = 0;
        if (eff == MAX_LEVELS_DEF && $urandom_range(1) == 0) cfg = $urandom_range(33, 63);
        r = $urandom_range(99);
        style = (r < 60) ? GROW_BUSHY : (r < 85) ? GROW_PATH : GROW_FAR;
        if (eff <= 4) run_tree(cfg, eff, style, $urandom_range(19) != 0, 1'b0, 1'b1);
        else if (eff <= 8) run_tree(cfg, eff, GROW_PATH, 1'b1, 1'b1, 1'b1);
        else run_tree(cfg, eff, GROW_BUSHY, 1'b0, 1'b0, 1'b1);
    endtask

    initial begin
        int ph;
        int phase_start;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default size: a close where the root must open, then stuck in error
        send_bits(32'b01, 2, 4'hA);
        // empty root, then a word after the finish
        set_levels(1);
        send_bits(32'b101, 3, 4'h5);
        // single full leaf at the root
        set_levels(1);
        send_bits(32'b1100, 4, 4'hF);
        // zero leaf consumed, then an open where a leaf close is due
        set_levels(1);
        send_bits(32'b111, 3, 4'h0);
        // node closed before its four children
        set_levels(2);
        send_bits(32'b1100, 4, 4'h6);
        // three empty quadrants, pause, leaf in the last one, then a fifth child
        set_levels(2);
        send_bits(32'b1101010, 7, 4'h3);
        wait_quiet();
        send_bits(32'b11001, 5, 4'h9);

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct <= 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct <= 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            phase_start = words_sent;
            if (ph == 0) begin
                run_tree(0, 1, GROW_BUSHY, 1'b1, 1'b0, 1'b0);
                run_tree(63, MAX_LEVELS_DEF, GROW_BUSHY, 1'b0, 1'b0, 1'b1);
                // one path down to a leaf of the widest matrix
                run_tree(MAX_LEVELS_DEF, MAX_LEVELS_DEF, GROW_DEEP, 1'b1, 1'b1, 1'b0);
            end
            if (ph == 2) begin
                stall_next = 1'b1;
                run_tree(4, 4, GROW_BUSHY, 1'b1, 1'b0, 1'b0);
            end
            while (words_sent - phase_start < PHASE_WORDS) random_tree();
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
sv/qpd_pkg.sv
sv/qpd_step.sv
sv/qpd_emit.sv
sv/quadtree_parens_decoder.sv
sv/qpd_checker.sv
test/qpd_pair_checker.sv
test/tb_top.sv
